>>> design/pr2d_pkg.sv
// Shared constants, types and the arctangent table for the 2D point rotator.
// Used by pr2d_cordic, point_rotator_2d and pr2d_checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package pr2d_pkg;

  // Field widths of the ports
  localparam int COORD_W  = 32;
  localparam int ANG_IN_W = 26;

  // Number formats
  localparam int FRAC_BITS    = 16;
  localparam int ANG_FRAC     = 24;
  localparam int ANG_SHIFT    = ANG_FRAC - FRAC_BITS;
  localparam int GUARD        = 8;
  localparam int CORDIC_STEPS = 24;
  localparam int ROT_STAGES   = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

  // Angle before fold, residual angle after fold, coordinate datapath
  localparam int ANG_W = 35;
  localparam int AW    = 34;
  localparam int DW    = 43;

  // Gain compensation multiply
  localparam int PX_W      = COORD_W + 1;
  localparam int MUL_W     = 2 * PX_W;
  localparam int MUL_SHIFT = 32 - GUARD;
  localparam logic signed [PX_W-1:0]  GAIN_Q32 = 33'sd2608131496;
  localparam logic signed [MUL_W-1:0] MUL_RND  = MUL_W'(64'sd1 <<< (MUL_SHIFT - 1));

  // Output rounding
  localparam int RND_W = DW - GUARD;
  localparam logic signed [DW-1:0]    FIN_RND   = DW'(64'sd1 <<< (GUARD - 1));
  localparam logic signed [RND_W-1:0] COORD_MAX = RND_W'(64'sd2147483647);
  localparam logic signed [RND_W-1:0] COORD_MIN = RND_W'(-64'sd2147483648);

  // Angle constants in degrees with ANG_FRAC fraction bits
  localparam logic signed [ANG_W-1:0] FULL_DEG    = ANG_W'(64'sd360 <<< ANG_FRAC);
  localparam logic signed [ANG_W-1:0] HALF_DEG    = ANG_W'(64'sd180 <<< ANG_FRAC);
  localparam logic signed [ANG_W-1:0] QUARTER_DEG = ANG_W'(64'sd90 <<< ANG_FRAC);

  // Pipeline registers from start to done: five front stages, the rotations and one output stage
  localparam int PIPE_LAT = ROT_STAGES + 6;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [AW-1:0] a;
  } rot_t;

  // round(atan(2^-i) in degrees * 2^24)
  function automatic logic signed [AW-1:0] atan_tab(input logic [4:0] idx);
    logic signed [AW-1:0] v;
    case (idx)
      5'd0:    v = 34'sd754974720;
      5'd1:    v = 34'sd445687602;
      5'd2:    v = 34'sd235489088;
      5'd3:    v = 34'sd119537938;
      5'd4:    v = 34'sd60000934;
      5'd5:    v = 34'sd30029717;
      5'd6:    v = 34'sd15018523;
      5'd7:    v = 34'sd7509720;
      5'd8:    v = 34'sd3754917;
      5'd9:    v = 34'sd1877466;
      5'd10:   v = 34'sd938734;
      5'd11:   v = 34'sd469367;
      5'd12:   v = 34'sd234684;
      5'd13:   v = 34'sd117342;
      5'd14:   v = 34'sd58671;
      5'd15:   v = 34'sd29335;
      5'd16:   v = 34'sd14668;
      5'd17:   v = 34'sd7334;
      5'd18:   v = 34'sd3667;
      5'd19:   v = 34'sd1833;
      5'd20:   v = 34'sd917;
      5'd21:   v = 34'sd458;
      5'd22:   v = 34'sd229;
      5'd23:   v = 34'sd115;
      5'd24:   v = 34'sd57;
      5'd25:   v = 34'sd29;
      5'd26:   v = 34'sd14;
      5'd27:   v = 34'sd7;
      5'd28:   v = 34'sd4;
      5'd29:   v = 34'sd2;
      5'd30:   v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> design/pr2d_cordic.sv
// Unrolled CORDIC rotation chain: one registered micro-rotation per stage.
// Depends on pr2d_pkg for rot_t, the stage count and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none
module pr2d_cordic (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire pr2d_pkg::rot_t rot_i,
  output logic               valid_o,
  output pr2d_pkg::rot_t     rot_o
);

  pr2d_pkg::rot_t st_q [pr2d_pkg::ROT_STAGES];
  logic           vld_q [pr2d_pkg::ROT_STAGES];

  for (genvar i = 0; i < pr2d_pkg::ROT_STAGES; i++) begin : g_stage
    pr2d_pkg::rot_t src;
    pr2d_pkg::rot_t st_d;
    logic           src_v;
    logic signed [pr2d_pkg::DW-1:0] sx;
    logic signed [pr2d_pkg::DW-1:0] sy;

    if (i == 0) begin : g_first
      assign src   = rot_i;
      assign src_v = valid_i;
    end else begin : g_next
      assign src   = st_q[i-1];
      assign src_v = vld_q[i-1];
    end

    always_comb begin
      sx = src.x >>> i;
      sy = src.y >>> i;
      // Turn toward zero residual angle
      if (!src.a[pr2d_pkg::AW-1]) begin
        st_d.x = src.x - sy;
        st_d.y = src.y + sx;
        st_d.a = src.a - pr2d_pkg::atan_tab(5'(i));
      end else begin
        st_d.x = src.x + sy;
        st_d.y = src.y - sx;
        st_d.a = src.a + pr2d_pkg::atan_tab(5'(i));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[i] <= st_d;
    end
  end

  assign valid_o = vld_q[pr2d_pkg::ROT_STAGES-1];
  assign rot_o   = st_q[pr2d_pkg::ROT_STAGES-1];

endmodule
`default_nettype wire

>>> design/point_rotator_2d.sv
// Clockwise 2D point rotation by CORDIC: angle reduction, gain compensation,
// the rotation chain in pr2d_cordic and output rounding. Depends on pr2d_pkg.
//
// One item enters per cycle and its result appears on done_o after passing through
// all pipeline registers, counted in PIPE_LAT (24 registered micro-rotation
// stages plus five front stages for angle negate, reduce, fold, gain multiply
// and rounding, plus one output stage). The pipeline never stops, so busy_o
// stays low and a result is shown for one cycle only: the receiver must take
// it when done_o is high. Outputs hold their last value between results.
`timescale 1ns / 1ps
`default_nettype none
module point_rotator_2d (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [pr2d_pkg::COORD_W-1:0]  x_in_i,
  input  wire logic signed [pr2d_pkg::COORD_W-1:0]  y_in_i,
  input  wire logic signed [pr2d_pkg::ANG_IN_W-1:0] angle_deg_i,
  output logic                                     busy_o,
  output logic                                     done_o,
  output logic signed [pr2d_pkg::COORD_W-1:0]       x_out_o,
  output logic signed [pr2d_pkg::COORD_W-1:0]       y_out_o,
  output logic                                     saturated_o
);

  localparam int CW = pr2d_pkg::COORD_W;
  localparam int PW = pr2d_pkg::PX_W;

  // Stage 1: take item, negate angle into internal format
  logic                                s1_v_q;
  logic signed [CW-1:0]                s1_x_q, s1_y_q;
  logic signed [pr2d_pkg::ANG_W-1:0]   s1_a_d, s1_a_q;
  // Stage 2: reduce into (-180, 180]
  logic                                s2_v_q;
  logic signed [CW-1:0]                s2_x_q, s2_y_q;
  logic signed [pr2d_pkg::ANG_W-1:0]   s2_a_d, s2_a_q;
  // Stage 3: fold into [-90, 90]
  logic                                s3_v_q;
  logic signed [PW-1:0]                s3_x_d, s3_y_d, s3_x_q, s3_y_q;
  logic signed [pr2d_pkg::ANG_W-1:0]   s3_wide;
  logic signed [pr2d_pkg::AW-1:0]      s3_a_d, s3_a_q;
  // Stage 4: gain products
  logic                                s4_v_q;
  logic signed [pr2d_pkg::MUL_W-1:0]   s4_px_d, s4_py_d, s4_px_q, s4_py_q;
  logic signed [pr2d_pkg::AW-1:0]      s4_a_q;
  // Stage 5: round products into the guard format
  logic                                s5_v_q;
  pr2d_pkg::rot_t                      s5_d, s5_q;
  // Rotation chain and output stage
  logic                                rot_v;
  pr2d_pkg::rot_t                      rot;
  logic signed [pr2d_pkg::RND_W-1:0]   fx_r, fy_r;
  logic signed [CW-1:0]                x_out_d, y_out_d, x_out_q, y_out_q;
  logic                                clip_x, clip_y;
  logic                                done_q, sat_q;

  function automatic logic signed [CW-1:0] clip_val(
    input logic signed [pr2d_pkg::RND_W-1:0] r
  );
    logic signed [CW-1:0] v;
    if (r > pr2d_pkg::COORD_MAX) begin
      v = CW'(pr2d_pkg::COORD_MAX);
    end else if (r < pr2d_pkg::COORD_MIN) begin
      v = CW'(pr2d_pkg::COORD_MIN);
    end else begin
      v = CW'(r);
    end
    return v;
  endfunction

  always_comb begin
    s1_a_d = (-pr2d_pkg::ANG_W'(angle_deg_i)) <<< pr2d_pkg::ANG_SHIFT;

    if (s1_a_q > pr2d_pkg::HALF_DEG) begin
      s2_a_d = s1_a_q - pr2d_pkg::FULL_DEG;
    end else if (s1_a_q <= -pr2d_pkg::HALF_DEG) begin
      s2_a_d = s1_a_q + pr2d_pkg::FULL_DEG;
    end else begin
      s2_a_d = s1_a_q;
    end

    // Fold by a half turn and negate the point to match
    if (s2_a_q > pr2d_pkg::QUARTER_DEG) begin
      s3_wide = s2_a_q - pr2d_pkg::HALF_DEG;
      s3_x_d  = -PW'(s2_x_q);
      s3_y_d  = -PW'(s2_y_q);
    end else if (s2_a_q < -pr2d_pkg::QUARTER_DEG) begin
      s3_wide = s2_a_q + pr2d_pkg::HALF_DEG;
      s3_x_d  = -PW'(s2_x_q);
      s3_y_d  = -PW'(s2_y_q);
    end else begin
      s3_wide = s2_a_q;
      s3_x_d  = PW'(s2_x_q);
      s3_y_d  = PW'(s2_y_q);
    end
    s3_a_d = pr2d_pkg::AW'(s3_wide);

    s4_px_d = s3_x_q * pr2d_pkg::GAIN_Q32;
    s4_py_d = s3_y_q * pr2d_pkg::GAIN_Q32;

    s5_d.x = pr2d_pkg::DW'((s4_px_q + pr2d_pkg::MUL_RND) >>> pr2d_pkg::MUL_SHIFT);
    s5_d.y = pr2d_pkg::DW'((s4_py_q + pr2d_pkg::MUL_RND) >>> pr2d_pkg::MUL_SHIFT);
    s5_d.a = s4_a_q;

    fx_r    = pr2d_pkg::RND_W'((rot.x + pr2d_pkg::FIN_RND) >>> pr2d_pkg::GUARD);
    fy_r    = pr2d_pkg::RND_W'((rot.y + pr2d_pkg::FIN_RND) >>> pr2d_pkg::GUARD);
    clip_x  = (fx_r > pr2d_pkg::COORD_MAX) || (fx_r < pr2d_pkg::COORD_MIN);
    clip_y  = (fy_r > pr2d_pkg::COORD_MAX) || (fy_r < pr2d_pkg::COORD_MIN);
    x_out_d = clip_val(fx_r);
    y_out_d = clip_val(fy_r);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_v_q <= start_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      done_q <= rot_v;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    s1_x_q  <= x_in_i;
    s1_y_q  <= y_in_i;
    s1_a_q  <= s1_a_d;
    s2_x_q  <= s1_x_q;
    s2_y_q  <= s1_y_q;
    s2_a_q  <= s2_a_d;
    s3_x_q  <= s3_x_d;
    s3_y_q  <= s3_y_d;
    s3_a_q  <= s3_a_d;
    s4_px_q <= s4_px_d;
    s4_py_q <= s4_py_d;
    s4_a_q  <= s3_a_q;
    s5_q    <= s5_d;
    if (rot_v) begin
      x_out_q <= x_out_d;
      y_out_q <= y_out_d;
      sat_q   <= clip_x || clip_y;
    end
  end

  pr2d_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s5_v_q),
    .rot_i   (s5_q),
    .valid_o (rot_v),
    .rot_o   (rot)
  );

  assign busy_o      = 1'b0;
  assign done_o      = done_q;
  assign x_out_o     = x_out_q;
  assign y_out_o     = y_out_q;
  assign saturated_o = sat_q;

endmodule
`default_nettype wire

>>> design/pr2d_checker.sv
// Port-level checks for point_rotator_2d, attached by the bind at the end.
// Depends on pr2d_pkg for the pipeline latency.
`timescale 1ns / 1ps
`default_nettype none
module pr2d_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                start_i,
  input wire logic signed [pr2d_pkg::COORD_W-1:0]  x_in_i,
  input wire logic signed [pr2d_pkg::COORD_W-1:0]  y_in_i,
  input wire logic signed [pr2d_pkg::ANG_IN_W-1:0] angle_deg_i,
  input wire logic                                busy_o,
  input wire logic                                done_o,
  input wire logic signed [pr2d_pkg::COORD_W-1:0]  x_out_o,
  input wire logic signed [pr2d_pkg::COORD_W-1:0]  y_out_o,
  input wire logic                                saturated_o
);

  localparam int LAT = pr2d_pkg::PIPE_LAT;

  logic sat_bound;
  logic angle_seen;

  assign sat_bound = (x_out_o == 32'sh7FFFFFFF) || (x_out_o == 32'sh80000000) ||
                     (y_out_o == 32'sh7FFFFFFF) || (y_out_o == 32'sh80000000);
  assign angle_seen = ^angle_deg_i || !(^angle_deg_i);

  // Every accepted item comes out after the fixed latency
  a_item_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("accepted item did not come out after the pipeline latency");

  // No result without an item accepted the latency before
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without a matching accepted item");

  // A clipped result shows a bound on at least one coordinate
  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturated_o) |-> sat_bound)
    else $error("saturated set but no coordinate at a bound");

  // The origin stays at the origin for any angle
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(start_i && !busy_o && angle_seen && (x_in_i == 32'sd0) &&
                     (y_in_i == 32'sd0), LAT))
    |-> ((x_out_o == 32'sd0) && (y_out_o == 32'sd0) && !saturated_o))
    else $error("origin did not map to the origin");

endmodule

bind point_rotator_2d pr2d_checker u_pr2d_checker (.*);
`default_nettype wire

>>> tb/pr2d_rot_check.sv
// Result checker for point_rotator_2d: predicts each rotated point from the
// accepted item and compares it with the next result. Depends on pr2d_pkg.
`timescale 1ns / 1ps
module pr2d_rot_check
  import pr2d_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic signed [COORD_W-1:0]  x_in_i,
  input  logic signed [COORD_W-1:0]  y_in_i,
  input  logic signed [ANG_IN_W-1:0] angle_deg_i,
  input  logic                       done_i,
  input  logic signed [COORD_W-1:0]  x_out_i,
  input  logic signed [COORD_W-1:0]  y_out_i,
  input  logic                       saturated_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      sat;
  } rotated_pt_t;

  localparam int MAX_REPORTS = 200;

  rotated_pt_t rotated_q[$];
  int          n_fail;

  // atan(2^-i) in degrees, 24 fraction bits
  longint atan_q24 [32] = '{
    754974720, 445687602, 235489088, 119537938,
    60000934, 30029717, 15018523, 7509720,
    3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335,
    14668, 7334, 3667, 1833,
    917, 458, 229, 115,
    57, 29, 14, 7,
    4, 2, 1, 0
  };

  // Drop the guard bits with round-half-up, then clip to the coordinate range.
  function automatic logic signed [COORD_W-1:0] round_sat(input longint v,
                                                          output logic clip);
    longint r;
    r = (v + (longint'(1) << (GUARD - 1))) >>> GUARD;
    clip = 1'b0;
    if (r > 64'sd2147483647) begin
      r = 64'sd2147483647;
      clip = 1'b1;
    end else if (r < -64'sd2147483648) begin
      r = -64'sd2147483648;
      clip = 1'b1;
    end
    return r[COORD_W-1:0];
  endfunction

  function automatic rotated_pt_t rotate_cw(input logic signed [COORD_W-1:0]  px,
                                            input logic signed [COORD_W-1:0]  py,
                                            input logic signed [ANG_IN_W-1:0] ang);
    longint      x, y, a, t, sx, sy;
    longint      full, half, quarter;
    logic        cx, cy;
    rotated_pt_t r;
    x       = px;
    y       = py;
    full    = longint'(360) << ANG_FRAC;
    half    = longint'(180) << ANG_FRAC;
    quarter = longint'(90) << ANG_FRAC;
    // Clockwise turn: negate, then reduce into (-180, 180]
    a = -longint'(ang) * (longint'(1) << (ANG_FRAC - FRAC_BITS));
    a = a % full;
    if (a > half) a -= full;
    else if (a <= -half) a += full;
    // Fold into [-90, 90] by turning the point half way round
    if (a > quarter) begin
      a -= half;
      x = -x;
      y = -y;
    end else if (a < -quarter) begin
      a += half;
      x = -x;
      y = -y;
    end
    x = (x * longint'(GAIN_Q32) + (longint'(1) << (31 - GUARD))) >>> (32 - GUARD);
    y = (y * longint'(GAIN_Q32) + (longint'(1) << (31 - GUARD))) >>> (32 - GUARD);
    for (int i = 0; i < ROT_STAGES; i++) begin
      sx = x >>> i;
      sy = y >>> i;
      if (a >= 0) begin
        t = x - sy;
        y = y + sx;
        a -= atan_q24[i];
      end else begin
        t = x + sy;
        y = y - sx;
        a += atan_q24[i];
      end
      x = t;
    end
    r.x   = round_sat(x, cx);
    r.y   = round_sat(y, cy);
    r.sat = cx | cy;
    return r;
  endfunction

  task automatic flag(input string field, input longint want, input longint got);
    n_fail++;
    if (n_fail <= MAX_REPORTS)
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rotated_pt_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (rotated_q.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("%0t: result expected none actual x_out %0d y_out %0d saturated %0d",
                     $time, x_out_i, y_out_i, saturated_i);
        end else begin
          want = rotated_q.pop_front();
          if (x_out_i !== want.x) flag("x_out", want.x, x_out_i);
          if (y_out_i !== want.y) flag("y_out", want.y, y_out_i);
          if (saturated_i !== want.sat) flag("saturated", want.sat, saturated_i);
        end
      end
      if (start_i && !busy_i)
        rotated_q.push_back(rotate_cw(x_in_i, y_in_i, angle_deg_i));
      pending_o    <= rotated_q.size();
      fail_count_o <= n_fail;
    end
  end

endmodule

>>> tb/testbench.sv
// Top of the point_rotator_2d testbench: clock, reset, directed and random
// points, idle bursts and the verdict. Depends on pr2d_pkg and pr2d_rot_check.
`timescale 1ns / 1ps
module testbench;
  import pr2d_pkg::*;

  localparam int DEG        = 1 << FRAC_BITS;
  localparam int ANG_LIM    = 360 * DEG;
  localparam int N_RANDOM   = 900;
  localparam int QUIET_TAIL = 100;
  localparam int STALL_LIM  = 2000;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       start_i     = 1'b0;
  logic signed [COORD_W-1:0]  x_in_i      = '0;
  logic signed [COORD_W-1:0]  y_in_i      = '0;
  logic signed [ANG_IN_W-1:0] angle_deg_i = '0;
  logic                       busy_o;
  logic                       done_o;
  logic signed [COORD_W-1:0]  x_out_o;
  logic signed [COORD_W-1:0]  y_out_o;
  logic                       saturated_o;
  int                         fail_count;
  int                         pending;
  int                         stall_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  point_rotator_2d uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .x_in_i      (x_in_i),
    .y_in_i      (y_in_i),
    .angle_deg_i (angle_deg_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .x_out_o     (x_out_o),
    .y_out_o     (y_out_o),
    .saturated_o (saturated_o)
  );

  pr2d_rot_check rot_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .x_in_i       (x_in_i),
    .y_in_i       (y_in_i),
    .angle_deg_i  (angle_deg_i),
    .done_i       (done_o),
    .x_out_i      (x_out_o),
    .y_out_i      (y_out_o),
    .saturated_i  (saturated_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Hold the item until the edge that takes it; start stays high for the next one.
  task automatic send_point(input logic signed [COORD_W-1:0]  x,
                            input logic signed [COORD_W-1:0]  y,
                            input logic signed [ANG_IN_W-1:0] ang);
    start_i     <= 1'b1;
    x_in_i      <= x;
    y_in_i      <= y;
    angle_deg_i <= ang;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic idle_for(input int n);
    start_i     <= 1'b0;
    x_in_i      <= $urandom;
    y_in_i      <= $urandom;
    angle_deg_i <= ANG_IN_W'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  // Stop sending until every result in flight has come back.
  task automatic settle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    logic signed [COORD_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = $urandom_range(0, 1 << 25) - (1 << 24);
      6: begin
        case ($urandom_range(0, 4))
          0:       v = 32'sh7fffffff;
          1:       v = 32'sh80000000;
          2:       v = 0;
          3:       v = -1;
          default: v = 1;
        endcase
      end
      default:    v = $signed($urandom) >>> 3;
    endcase
    return v;
  endfunction

  function automatic logic signed [ANG_IN_W-1:0] rand_angle();
    int a;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11:
        a = int'($urandom_range(0, 2 * ANG_LIM)) - ANG_LIM;
      12, 13, 14, 15:
        // near a multiple of a quarter turn, where the fold decides
        a = (int'($urandom_range(0, 8)) - 4) * 90 * DEG + int'($urandom_range(0, 4)) - 2;
      16, 17:
        a = int'($urandom_range(0, 2 * DEG)) - DEG;
      default:
        a = $urandom;
    endcase
    return ANG_IN_W'(a);
  endfunction

  // End the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles + 1 >= STALL_LIM) begin
          $display("%0t: nothing accepted for %0d cycles", $time, STALL_LIM);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: quarter and half turns, fold boundaries, wrap and clipping
    send_point(32'sd65536, 32'sd0, ANG_IN_W'(0));
    send_point(32'sd65536, 32'sd0, ANG_IN_W'(90 * DEG));
    send_point(32'sd65536, 32'sd0, ANG_IN_W'(-90 * DEG));
    send_point(32'sd65536, 32'sd32768, ANG_IN_W'(180 * DEG));
    send_point(32'sd65536, 32'sd32768, ANG_IN_W'(-180 * DEG));
    send_point(32'sd98304, -32'sd131072, ANG_IN_W'(180 * DEG - 1));
    send_point(32'sd98304, -32'sd131072, ANG_IN_W'(90 * DEG + 1));
    send_point(32'sd98304, -32'sd131072, ANG_IN_W'(-90 * DEG - 1));
    send_point(32'sd200000, 32'sd300000, ANG_IN_W'(360 * DEG));
    send_point(32'sd200000, 32'sd300000, ANG_IN_W'(-360 * DEG));
    send_point(32'sd200000, 32'sd300000, ANG_IN_W'(270 * DEG));
    send_point(32'sd200000, 32'sd300000, 26'sh1ffffff);
    send_point(32'sd200000, 32'sd300000, 26'sh2000000);
    send_point(32'sh7fffffff, 32'sh7fffffff, ANG_IN_W'(45 * DEG));
    send_point(32'sh80000000, 32'sh80000000, ANG_IN_W'(45 * DEG));
    send_point(32'sh7fffffff, 32'sh80000000, ANG_IN_W'(-45 * DEG));
    send_point(32'sh80000000, 32'sd0, ANG_IN_W'(180 * DEG));
    send_point(32'sh80000000, 32'sh7fffffff, ANG_IN_W'(0));
    send_point(32'sh7fffffff, 32'sh7fffffff, ANG_IN_W'(0));
    send_point(32'sd0, 32'sd0, ANG_IN_W'(123 * DEG));
    send_point(-32'sd1, 32'sd1, ANG_IN_W'(30 * DEG));
    send_point(32'sd1, -32'sd1, ANG_IN_W'(-1));
    idle_for(3);
    send_point(32'sh12345678, -32'sh0abcdef0, ANG_IN_W'(17 * DEG + 12345));
    settle();

    for (int k = 0; k < N_RANDOM; k++) begin
      send_point(rand_coord(), rand_coord(), rand_angle());
      if (k == N_RANDOM / 2)
        settle();
      else if (k < N_RANDOM - QUIET_TAIL && $urandom_range(0, 7) == 0)
        idle_for($urandom_range(1, 19));
    end

    settle();
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
